// ----- design/pcfs_pkg.sv -----
// shared types, constants and font lookup for the pov clock frame sequencer
`default_nettype none

package pcfs_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_SWEEP = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        UNIT_HOUR   = 2'd0,
        UNIT_MINUTE = 2'd1,
        UNIT_SECOND = 2'd2
    } t_unit;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_time;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_digits;

    localparam logic [5:0] SEC_MAX    = 6'd59;
    localparam logic [5:0] MIN_MAX    = 6'd59;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [6:0] SET_MAX_HR = 7'd23;
    localparam logic [6:0] SET_MAX_MS = 7'd59;
    localparam logic [5:0] ROW_SPLIT  = 6'd30;

    localparam logic [7:0] ROW_MARK  = 8'h08;
    localparam logic [7:0] ROW_LOW   = 8'h02;
    localparam logic [7:0] ROW_HIGH  = 8'h04;
    localparam logic [7:0] COL_MARK  = 8'h80;
    localparam logic [7:0] COL_BLANK = 8'h00;
    localparam logic [5:0] WAIT_MAX  = 6'd59;
    localparam logic [5:0] WAIT_GLY  = 6'd2;
    localparam logic [5:0] WAIT_NONE = 6'd0;

    localparam int unsigned GLYPH_COUNT = 11;
    localparam logic [3:0]  GLYPH_COLON = 4'd10;
    localparam logic [2:0]  GLYPH_LAST  = 3'd4;

    // five font columns per glyph, column 0 in the top byte
    localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
        40'h3E_41_41_41_3E,
        40'h00_00_10_20_7F,
        40'h27_49_49_49_31,
        40'h22_41_49_49_36,
        40'h0C_14_24_7F_04,
        40'h7A_49_49_49_46,
        40'h3E_49_49_49_26,
        40'h40_47_48_50_60,
        40'h36_49_49_49_36,
        40'h32_49_49_49_3E,
        40'h00_00_42_00_00
    };

    function automatic logic [7:0] glyph_col(input logic [3:0] g, input logic [2:0] c);
        logic [7:0] bits;
        logic [5:0] pos;
        bits = COL_BLANK;
        pos  = 6'((GLYPH_LAST - c) * 4'd8);
        if (g <= GLYPH_COLON && c <= GLYPH_LAST) begin
            bits = GLYPH_ROM[g][pos +: 8];
        end
        return bits;
    endfunction

    // split 0..59 into decimal digits with a compare ladder
    function automatic t_digits split_digits(input logic [5:0] v);
        t_digits d;
        if (v >= 6'd50) begin
            d.tens = 4'd5;
        end else if (v >= 6'd40) begin
            d.tens = 4'd4;
        end else if (v >= 6'd30) begin
            d.tens = 4'd3;
        end else if (v >= 6'd20) begin
            d.tens = 4'd2;
        end else if (v >= 6'd10) begin
            d.tens = 4'd1;
        end else begin
            d.tens = 4'd0;
        end
        d.units = 4'(v - 6'(d.tens * 4'd10));
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- design/pcfs_in_if.sv -----
// command channel: operation, unit and value
`default_nettype none

interface pcfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [1:0] set_unit;
    logic [6:0] set_value;

    modport source (output valid, output operation, output set_unit, output set_value,
                    input ready);
    modport sink   (input valid, input operation, input set_unit, input set_value,
                    output ready);
endinterface

`default_nettype wire

// ----- design/pcfs_out_if.sv -----
// frame channel: one beat per display frame
`default_nettype none

interface pcfs_out_if;
    logic       valid;
    logic       ready;
    logic       frame_kind;
    logic [7:0] row_code;
    logic [7:0] column_bits;
    logic [5:0] wait_units;
    logic       last_frame;

    modport source (output valid, output frame_kind, output row_code, output column_bits,
                    output wait_units, output last_frame, input ready);
    modport sink   (input valid, input frame_kind, input row_code, input column_bits,
                    input wait_units, input last_frame, output ready);
endinterface

`default_nettype wire

// ----- design/pcfs_time.sv -----
// time of day counters with one-second tick and clamped unit load
`default_nettype none

module pcfs_time (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_tick,
    input  wire logic           i_set,
    input  wire logic [1:0]     i_set_unit,
    input  wire logic [6:0]     i_set_value,
    output pcfs_pkg::t_time     o_time
);

    pcfs_pkg::t_time r_time;
    pcfs_pkg::t_time n_time;

    always_comb begin
        n_time = r_time;
        if (i_tick) begin
            if (r_time.second >= pcfs_pkg::SEC_MAX) begin
                n_time.second = '0;
                if (r_time.minute >= pcfs_pkg::MIN_MAX) begin
                    n_time.minute = '0;
                    n_time.hour   = (r_time.hour >= pcfs_pkg::HOUR_MAX) ? '0
                                                                        : r_time.hour + 5'd1;
                end else begin
                    n_time.minute = r_time.minute + 6'd1;
                end
            end else begin
                n_time.second = r_time.second + 6'd1;
            end
        end else if (i_set) begin
            case (i_set_unit)
                pcfs_pkg::UNIT_HOUR: begin
                    n_time.hour = (i_set_value > pcfs_pkg::SET_MAX_HR) ? pcfs_pkg::HOUR_MAX
                                                                      : i_set_value[4:0];
                end
                pcfs_pkg::UNIT_MINUTE: begin
                    n_time.minute = (i_set_value > pcfs_pkg::SET_MAX_MS) ? pcfs_pkg::MIN_MAX
                                                                        : i_set_value[5:0];
                end
                pcfs_pkg::UNIT_SECOND: begin
                    n_time.second = (i_set_value > pcfs_pkg::SET_MAX_MS) ? pcfs_pkg::SEC_MAX
                                                                        : i_set_value[5:0];
                end
                default: begin
                    n_time = r_time;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else begin
            r_time <= n_time;
        end
    end

    assign o_time = r_time;

endmodule

`default_nettype wire

// ----- design/pcfs_seq.sv -----
// sweep sequencer: walks segments and columns, one frame per beat through a shared font lookup
`default_nettype none

module pcfs_seq #(
    parameter int unsigned FONT_COLUMNS = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire pcfs_pkg::t_time i_time,
    output logic                 o_busy,
    pcfs_out_if.source           o_frame
);

    localparam int unsigned CW = $clog2(FONT_COLUMNS);

    typedef enum logic [3:0] {
        SEG_LEAD, SEG_H_TENS, SEG_H_SPACE, SEG_H_UNITS, SEG_COLON_HM,
        SEG_M_TENS, SEG_M_SPACE, SEG_M_UNITS, SEG_COLON_MS,
        SEG_S_TENS, SEG_S_SPACE, SEG_S_UNITS, SEG_TRAIL
    } t_seg;

    t_seg               r_seg;
    logic [CW-1:0]      r_col;
    logic               r_busy;
    logic               r_valid;
    logic               r_kind;
    logic [7:0]         r_row;
    logic [7:0]         r_bits;
    logic [5:0]         r_wait;
    logic               r_last;

    logic               n_kind;
    logic [7:0]         n_row;
    logic [7:0]         n_bits;
    logic [5:0]         n_wait;
    logic               n_last;
    logic               seg_end;
    logic               load;
    logic [5:0]         sel_val;
    pcfs_pkg::t_digits  dig;
    logic [3:0]         gcode;
    logic [7:0]         disp_row;

    assign load     = r_busy && (!r_valid || o_frame.ready);
    assign disp_row = (i_time.second > pcfs_pkg::ROW_SPLIT) ? pcfs_pkg::ROW_HIGH
                                                             : pcfs_pkg::ROW_LOW;

    // one digit splitter shared across the three time fields
    always_comb begin
        case (r_seg)
            SEG_H_TENS, SEG_H_UNITS: sel_val = {1'b0, i_time.hour};
            SEG_M_TENS, SEG_M_UNITS: sel_val = i_time.minute;
            default:                 sel_val = i_time.second;
        endcase
        dig = pcfs_pkg::split_digits(sel_val);
        case (r_seg)
            SEG_H_TENS, SEG_M_TENS, SEG_S_TENS:    gcode = dig.tens;
            SEG_H_UNITS, SEG_M_UNITS, SEG_S_UNITS: gcode = dig.units;
            default:                               gcode = pcfs_pkg::GLYPH_COLON;
        endcase
    end

    always_comb begin
        n_kind  = 1'b1;
        n_row   = disp_row;
        n_bits  = pcfs_pkg::glyph_col(gcode, 3'(r_col));
        n_wait  = pcfs_pkg::WAIT_GLY;
        n_last  = 1'b0;
        seg_end = (r_col == CW'(FONT_COLUMNS - 1));
        case (r_seg)
            SEG_LEAD: begin
                n_kind  = 1'b0;
                n_row   = pcfs_pkg::ROW_MARK;
                seg_end = (r_col == CW'(2));
                if (r_col == '0) begin
                    n_bits = pcfs_pkg::COL_BLANK;
                    n_wait = pcfs_pkg::WAIT_MAX - i_time.second;
                end else if (r_col == CW'(1)) begin
                    n_bits = pcfs_pkg::COL_MARK;
                    n_wait = i_time.second;
                end else begin
                    n_bits = pcfs_pkg::COL_MARK;
                    n_wait = pcfs_pkg::WAIT_NONE;
                end
            end
            SEG_H_SPACE, SEG_M_SPACE, SEG_S_SPACE: begin
                n_bits  = pcfs_pkg::COL_BLANK;
                seg_end = 1'b1;
            end
            SEG_TRAIL: begin
                n_kind  = 1'b0;
                n_row   = pcfs_pkg::ROW_MARK;
                seg_end = (r_col == CW'(1));
                if (r_col == '0) begin
                    n_bits = pcfs_pkg::COL_MARK;
                    n_wait = i_time.second;
                end else begin
                    n_bits = pcfs_pkg::COL_BLANK;
                    n_wait = pcfs_pkg::WAIT_NONE;
                    n_last = 1'b1;
                end
            end
            default: begin
                n_kind = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_seg   <= SEG_LEAD;
            r_col   <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_seg  <= SEG_LEAD;
                r_col  <= '0;
            end else if (load) begin
                if (seg_end) begin
                    r_col <= '0;
                    if (r_seg == SEG_TRAIL) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_seg <= t_seg'(r_seg + 4'd1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_kind <= n_kind;
            r_row  <= n_row;
            r_bits <= n_bits;
            r_wait <= n_wait;
            r_last <= n_last;
        end
    end

    assign o_busy              = r_busy;
    assign o_frame.valid       = r_valid;
    assign o_frame.frame_kind  = r_kind;
    assign o_frame.row_code    = r_row;
    assign o_frame.column_bits = r_bits;
    assign o_frame.wait_units  = r_wait;
    assign o_frame.last_frame  = r_last;

endmodule

`default_nettype wire

// ----- design/pov_clock_frame_sequencer.sv -----
// top level: time keeping and sweep frame sequencing for the pov clock display
//
//   port      dir   role
//   i_cmd     in    tick, set unit or start sweep, one beat per command
//   o_frame   out   display frames, 8 * FONT_COLUMNS + 8 beats per sweep
//
// a tick or set takes effect in the cycle after its beat and adds no wait
// a sweep gives one frame per cycle while o_frame is ready, paced by the segment
// and column counters of the sequencer
// i_cmd is held off while a sweep is running; a stall on o_frame holds the sweep
// reset is synchronous and clears the time to 00:00:00
`default_nettype none

module pov_clock_frame_sequencer #(
    parameter int unsigned FONT_COLUMNS = 5
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pcfs_in_if.sink     i_cmd,
    pcfs_out_if.source  o_frame
);

    pcfs_pkg::t_time time_now;
    logic            busy;
    logic            accept;
    logic            tick;
    logic            set;
    logic            start;

    assign i_cmd.ready = !busy;
    assign accept      = i_cmd.valid && !busy;
    assign tick        = accept && (i_cmd.operation == pcfs_pkg::OP_TICK);
    assign set         = accept && (i_cmd.operation == pcfs_pkg::OP_SET);
    assign start       = accept && (i_cmd.operation == pcfs_pkg::OP_SWEEP);

    pcfs_time u_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_set       (set),
        .i_set_unit  (i_cmd.set_unit),
        .i_set_value (i_cmd.set_value),
        .o_time      (time_now)
    );

    pcfs_seq #(
        .FONT_COLUMNS (FONT_COLUMNS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_time  (time_now),
        .o_busy  (busy),
        .o_frame (o_frame)
    );

endmodule

`default_nettype wire
